// ----- rtl/tile_map_pixel_collision_defines.svh -----
// Assertion macros used by the checker of the tile map collision block.
`ifndef TILE_MAP_PIXEL_COLLISION_DEFINES_SVH
`define TILE_MAP_PIXEL_COLLISION_DEFINES_SVH

// Next-cycle implication, ignored while reset is low.
`define TMPC_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TMPC_ASSERT_RST(label, pre, post, msg) \
  label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/tmpc_pkg.sv -----
`default_nettype none

package tmpc_pkg;

  // request opcodes
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_RECT   = 2'd1;
  localparam logic [1:0] ACT_POINT  = 2'd2;
  localparam logic [1:0] ACT_HAS_ID = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MAP_W = 2'd0;
  localparam logic [1:0] CFG_MAP_H = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  // number of shapes in the ROM that can ever be used
  localparam logic [5:0] SHAPE_COUNT = 6'd32;

  // row mask building blocks
  localparam logic [15:0] ROW_FULL = 16'hFFFF;
  localparam logic [15:0] ROW_TAIL = 16'h7FFF;
  localparam logic [3:0]  ROW_LAST = 4'd15;

  // pixel coordinate inside the map (map is at most 127 tiles of 16 pixels)
  typedef logic [10:0] px_t;

  // result of clipping one axis of a request to the map
  typedef struct packed {
    logic empty;
    px_t  lo;
    px_t  hi;
  } clip_t;

  // shape ROM: 16 rows of 16 pixels, MSB is pixel 0 of the row
  localparam logic [15:0] SHAPE_ROM [32][16] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'h0001, 16'h0003, 16'h0007, 16'h000F, 16'h001F, 16'h003F, 16'h007F, 16'h00FF,
      16'h01FF, 16'h03FF, 16'h07FF, 16'h0FFF, 16'h1FFF, 16'h3FFF, 16'h7FFF, 16'hFFFF},
    '{16'hFFFF, 16'h7FFF, 16'h3FFF, 16'h1FFF, 16'h0FFF, 16'h07FF, 16'h03FF, 16'h01FF,
      16'h00FF, 16'h007F, 16'h003F, 16'h001F, 16'h000F, 16'h0007, 16'h0003, 16'h0001},
    '{16'h8000, 16'hC000, 16'hE000, 16'hF000, 16'hF800, 16'hFC00, 16'hFE00, 16'hFF00,
      16'hFF80, 16'hFFC0, 16'hFFE0, 16'hFFF0, 16'hFFF8, 16'hFFFC, 16'hFFFE, 16'hFFFF},
    '{16'hFFFF, 16'hFFFE, 16'hFFFC, 16'hFFF8, 16'hFFF0, 16'hFFE0, 16'hFFC0, 16'hFF80,
      16'hFF00, 16'hFE00, 16'hFC00, 16'hF800, 16'hF000, 16'hE000, 16'hC000, 16'h8000},
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0003, 16'h000F, 16'h003F, 16'h00FF, 16'h03FF, 16'h0FFF, 16'h3FFF, 16'hFFFF},
    '{16'hFFFF, 16'h3FFF, 16'h0FFF, 16'h03FF, 16'h00FF, 16'h003F, 16'h000F, 16'h0003,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'hC000, 16'hF000, 16'hFC00, 16'hFF00, 16'hFFC0, 16'hFFF0, 16'hFFFC, 16'hFFFF},
    '{16'hFFFF, 16'hFFFC, 16'hFFF0, 16'hFFC0, 16'hFF00, 16'hFC00, 16'hF000, 16'hC000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0001, 16'h0001, 16'h0003, 16'h0003, 16'h0007, 16'h0007, 16'h000F, 16'h000F,
      16'h001F, 16'h001F, 16'h003F, 16'h003F, 16'h007F, 16'h007F, 16'h00FF, 16'h00FF},
    '{16'h00FF, 16'h00FF, 16'h007F, 16'h007F, 16'h003F, 16'h003F, 16'h001F, 16'h001F,
      16'h000F, 16'h000F, 16'h0007, 16'h0007, 16'h0003, 16'h0003, 16'h0001, 16'h0001},
    '{16'h8000, 16'h8000, 16'hC000, 16'hC000, 16'hE000, 16'hE000, 16'hF000, 16'hF000,
      16'hF800, 16'hF800, 16'hFC00, 16'hFC00, 16'hFE00, 16'hFE00, 16'hFF00, 16'hFF00},
    '{16'hFF00, 16'hFF00, 16'hFE00, 16'hFE00, 16'hFC00, 16'hFC00, 16'hF800, 16'hF800,
      16'hF000, 16'hF000, 16'hE000, 16'hE000, 16'hC000, 16'hC000, 16'h8000, 16'h8000},
    '{16'h0003, 16'h000F, 16'h003F, 16'h00FF, 16'h03FF, 16'h0FFF, 16'h3FFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'h3FFF, 16'h0FFF, 16'h03FF, 16'h00FF, 16'h003F, 16'h000F, 16'h0003},
    '{16'hC000, 16'hF000, 16'hFC00, 16'hFF00, 16'hFFC0, 16'hFFF0, 16'hFFFC, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFC, 16'hFFF0, 16'hFFC0, 16'hFF00, 16'hFC00, 16'hF000, 16'hC000},
    '{16'h01FF, 16'h01FF, 16'h03FF, 16'h03FF, 16'h07FF, 16'h07FF, 16'h0FFF, 16'h0FFF,
      16'h1FFF, 16'h1FFF, 16'h3FFF, 16'h3FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF},
    '{16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h3FFF, 16'h3FFF, 16'h1FFF, 16'h1FFF,
      16'h0FFF, 16'h0FFF, 16'h07FF, 16'h07FF, 16'h03FF, 16'h03FF, 16'h01FF, 16'h01FF},
    '{16'hFF80, 16'hFF80, 16'hFFC0, 16'hFFC0, 16'hFFE0, 16'hFFE0, 16'hFFF0, 16'hFFF0,
      16'hFFF8, 16'hFFF8, 16'hFFFC, 16'hFFFC, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF},
    '{16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFC, 16'hFFFC, 16'hFFF8, 16'hFFF8,
      16'hFFF0, 16'hFFF0, 16'hFFE0, 16'hFFE0, 16'hFFC0, 16'hFFC0, 16'hFF80, 16'hFF80},
    '{default: 16'h0000},
    '{default: 16'h0000},
    '{default: 16'h0000},
    '{default: 16'h0000},
    '{default: 16'h0000},
    '{default: 16'h0000},
    '{default: 16'h0000},
    '{default: 16'h0000},
    '{default: 16'h0000},
    '{default: 16'h0000}
  };

endpackage

`default_nettype wire

// ----- rtl/tile_map_pixel_collision.sv -----
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-----------------------------------------
// in        | input     | in_valid/in_stall  | action, pos_x/y, rect_w/h, tile_index/value
// out       | output    | out_valid/out_stall| hit
// cfg       | input     | cfg_we             | cfg_index, cfg_wdata
//
// A write request goes from idle straight to the result state. Point and rectangle
// requests clip x and y, ending at an empty clip; else they form the row base, then read
// and test each covered tile, rectangles one shape row at a time in the one row tester.
// After reset a clearing pass zeroes all MAP_ENTRIES map entries; in_stall is high.
// A finished result waits in the output register, so a new request is taken
// while out_stall holds the previous result.
`default_nettype none

module tile_map_pixel_collision #(
  parameter int MAP_ENTRIES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_action,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic [10:0]        in_rect_w,
  input  wire logic [10:0]        in_rect_h,
  input  wire logic [11:0]        in_tile_index,
  input  wire logic [7:0]         in_tile_value,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_hit,
  // configuration port
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [6:0]         cfg_wdata
);

  localparam int AW = $clog2(MAP_ENTRIES);
  localparam int CW = AW + 1;
  localparam int IW = (AW > 14) ? AW : 14;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CLIPX  = 4'd2;
  localparam logic [3:0] S_CLIPY  = 4'd3;
  localparam logic [3:0] S_BASE   = 4'd4;
  localparam logic [3:0] S_READ   = 4'd5;
  localparam logic [3:0] S_TILE   = 4'd6;
  localparam logic [3:0] S_ROWS   = 4'd7;
  localparam logic [3:0] S_RESULT = 4'd8;

  // control state
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [6:0]    map_w_r, map_h_r;
  logic [5:0]    limit_r;

  // request and walk registers
  logic [1:0]         action_r, action_nxt;
  logic signed [15:0] pos_x_r, pos_x_nxt;
  logic signed [15:0] pos_y_r, pos_y_nxt;
  logic [10:0]        rect_w_r, rect_w_nxt;
  logic [10:0]        rect_h_r, rect_h_nxt;
  logic [7:0]         val_r, val_nxt;
  tmpc_pkg::px_t      x0_r, x0_nxt, x1_r, x1_nxt;
  tmpc_pkg::px_t      y0_r, y0_nxt, y1_r, y1_nxt;
  logic [6:0]         tx_r, tx_nxt, ty_r, ty_nxt;
  logic [IW-1:0]      row_base_r, row_base_nxt;
  logic               in_range_r, in_range_nxt;
  logic [3:0]         row_r, row_nxt;
  logic [4:0]         tile_r, tile_nxt;
  logic               hit_r, hit_nxt;
  logic               out_hit_r, out_hit_nxt;

  // datapath signals
  logic               accept;
  logic               clip_is_x;
  logic signed [15:0] clip_pos;
  logic [10:0]        clip_len;
  logic [6:0]         clip_tiles;
  tmpc_pkg::clip_t    clip;
  logic [IW-1:0]      tile_idx;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;
  logic [7:0]         tile_id;
  logic [5:0]         eff_lim;
  logic               shaped;
  logic [3:0]         r0, r1, c0, c1;
  logic [4:0]         rt_tile;
  logic [3:0]         rt_row, rt_c0, rt_c1;
  logic               row_hit;
  logic               step_tile;
  logic               load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // shared axis clipper: x in S_CLIPX, y otherwise
  assign clip_is_x  = (state_r == S_CLIPX);
  assign clip_pos   = clip_is_x ? pos_x_r : pos_y_r;
  assign clip_len   = (action_r == tmpc_pkg::ACT_POINT) ? 11'd1 :
                      (clip_is_x ? rect_w_r : rect_h_r);
  assign clip_tiles = clip_is_x ? map_w_r : map_h_r;

  tmpc_axis_clip u_clip (
    .pos   (clip_pos),
    .len   (clip_len),
    .tiles (clip_tiles),
    .clip  (clip)
  );

  // map store: clearing sweep or request write, read at the walked tile
  assign tile_idx  = row_base_r + IW'(tx_r);
  assign ram_we    = (state_r == S_CLEAR) ||
                     (accept && (in_action == tmpc_pkg::ACT_WRITE) &&
                      (32'(in_tile_index) < MAP_ENTRIES));
  assign ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r[AW-1:0] : AW'(in_tile_index);
  assign ram_wdata = (state_r == S_CLEAR) ? 8'd0 : in_tile_value;

  tmpc_map_ram #(
    .DEPTH (MAP_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (tile_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // tile under test; entries beyond the store read as empty
  assign tile_id = in_range_r ? ram_rdata : 8'd0;
  assign eff_lim = (limit_r < tmpc_pkg::SHAPE_COUNT) ? limit_r : tmpc_pkg::SHAPE_COUNT;
  assign shaped  = (tile_id < {2'd0, eff_lim});

  // covered rows and columns of the current tile
  assign r0 = (ty_r == y0_r[10:4]) ? y0_r[3:0] : 4'd0;
  assign r1 = (ty_r == y1_r[10:4]) ? y1_r[3:0] : tmpc_pkg::ROW_LAST;
  assign c0 = (tx_r == x0_r[10:4]) ? x0_r[3:0] : 4'd0;
  assign c1 = (tx_r == x1_r[10:4]) ? x1_r[3:0] : tmpc_pkg::ROW_LAST;

  // shared row tester: single pixel for points, row walk for rectangles
  assign rt_tile = (state_r == S_TILE) ? tile_id[4:0] : tile_r;
  assign rt_row  = (state_r == S_TILE) ? y0_r[3:0] : row_r;
  assign rt_c0   = (state_r == S_TILE) ? x0_r[3:0] : c0;
  assign rt_c1   = (state_r == S_TILE) ? x0_r[3:0] : c1;

  tmpc_row_test u_row (
    .tile (rt_tile),
    .row  (rt_row),
    .c0   (rt_c0),
    .c1   (rt_c1),
    .hit  (row_hit)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    action_nxt   = action_r;
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    rect_w_nxt   = rect_w_r;
    rect_h_nxt   = rect_h_r;
    val_nxt      = val_r;
    x0_nxt       = x0_r;
    x1_nxt       = x1_r;
    y0_nxt       = y0_r;
    y1_nxt       = y1_r;
    tx_nxt       = tx_r;
    ty_nxt       = ty_r;
    row_base_nxt = row_base_r;
    in_range_nxt = in_range_r;
    row_nxt      = row_r;
    tile_nxt     = tile_r;
    hit_nxt      = hit_r;
    step_tile    = 1'b0;
    load_out     = 1'b0;

    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + CW'(1);
        if (clr_cnt_r == CW'(MAP_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          action_nxt = in_action;
          pos_x_nxt  = in_pos_x;
          pos_y_nxt  = in_pos_y;
          rect_w_nxt = in_rect_w;
          rect_h_nxt = in_rect_h;
          val_nxt    = in_tile_value;
          hit_nxt    = 1'b0;
          state_nxt  = (in_action == tmpc_pkg::ACT_WRITE) ? S_RESULT : S_CLIPX;
        end
      end
      S_CLIPX: begin
        x0_nxt = clip.lo;
        x1_nxt = clip.hi;
        if (clip.empty) begin
          hit_nxt   = (action_r == tmpc_pkg::ACT_POINT);
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_CLIPY;
        end
      end
      S_CLIPY: begin
        y0_nxt = clip.lo;
        y1_nxt = clip.hi;
        ty_nxt = clip.lo[10:4];
        tx_nxt = x0_r[10:4];
        if (clip.empty) begin
          hit_nxt   = (action_r == tmpc_pkg::ACT_POINT);
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        row_base_nxt = IW'({7'd0, ty_r} * {7'd0, map_w_r});
        state_nxt    = S_READ;
      end
      S_READ: begin
        in_range_nxt = (32'(tile_idx) < MAP_ENTRIES);
        state_nxt    = S_TILE;
      end
      S_TILE: begin
        case (action_r)
          tmpc_pkg::ACT_HAS_ID: begin
            if (tile_id == val_r) begin
              hit_nxt   = 1'b1;
              state_nxt = S_RESULT;
            end else begin
              step_tile = 1'b1;
            end
          end
          tmpc_pkg::ACT_POINT: begin
            state_nxt = S_RESULT;
            if (tile_id <= 8'd1) begin
              hit_nxt = tile_id[0];
            end else if (!shaped) begin
              hit_nxt = 1'b0;
            end else begin
              hit_nxt = row_hit;
            end
          end
          default: begin
            // rectangle: empty and unshaped tiles are skipped, solid tile hits
            if ((tile_id == 8'd0) || !shaped) begin
              step_tile = 1'b1;
            end else if (tile_id == 8'd1) begin
              hit_nxt   = 1'b1;
              state_nxt = S_RESULT;
            end else begin
              tile_nxt  = tile_id[4:0];
              row_nxt   = r0;
              state_nxt = S_ROWS;
            end
          end
        endcase
      end
      S_ROWS: begin
        if (row_hit) begin
          hit_nxt   = 1'b1;
          state_nxt = S_RESULT;
        end else if (row_r == r1) begin
          step_tile = 1'b1;
        end else begin
          row_nxt = row_r + 4'd1;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // move to the next covered tile, row by row
    if (step_tile) begin
      if (tx_r == x1_r[10:4]) begin
        if (ty_r == y1_r[10:4]) begin
          hit_nxt   = 1'b0;
          state_nxt = S_RESULT;
        end else begin
          ty_nxt       = ty_r + 7'd1;
          tx_nxt       = x0_r[10:4];
          row_base_nxt = row_base_r + IW'(map_w_r);
          state_nxt    = S_READ;
        end
      end else begin
        tx_nxt    = tx_r + 7'd1;
        state_nxt = S_READ;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = out_hit_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r <= 7'd64;
      map_h_r <= 7'd64;
      limit_r <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        tmpc_pkg::CFG_MAP_W: map_w_r <= cfg_wdata;
        tmpc_pkg::CFG_MAP_H: map_h_r <= cfg_wdata;
        tmpc_pkg::CFG_LIMIT: limit_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    action_r   <= action_nxt;
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
    rect_w_r   <= rect_w_nxt;
    rect_h_r   <= rect_h_nxt;
    val_r      <= val_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y0_r       <= y0_nxt;
    y1_r       <= y1_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    row_base_r <= row_base_nxt;
    in_range_r <= in_range_nxt;
    row_r      <= row_nxt;
    tile_r     <= tile_nxt;
    hit_r      <= hit_nxt;
    out_hit_r  <= out_hit_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

`default_nettype wire

// ----- rtl/tmpc_map_ram.sv -----
`default_nettype none

// Tile map store: one write port, one read port with registered data.
module tmpc_map_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/tmpc_axis_clip.sv -----
`default_nettype none

// Clips one axis of a request to [0, 16 * tiles). Shared by x and y.
module tmpc_axis_clip (
  input  wire logic signed [15:0] pos,
  input  wire logic        [10:0] len,
  input  wire logic        [6:0]  tiles,
  output tmpc_pkg::clip_t         clip
);

  logic signed [17:0] pos_e;
  logic signed [17:0] end_e;
  logic signed [17:0] size_e;
  logic signed [17:0] lo_e;
  logic signed [17:0] hi_e;
  logic signed [17:0] last_e;

  always_comb begin
    pos_e  = {{2{pos[15]}}, pos};
    end_e  = pos_e + $signed({7'd0, len});
    size_e = $signed({7'd0, tiles, 4'd0});
    // lower bound at zero, upper bound at map edge (exclusive)
    lo_e   = pos_e[17] ? 18'sd0 : pos_e;
    hi_e   = (end_e < size_e) ? end_e : size_e;
    last_e = hi_e - 18'sd1;
    clip.empty = (hi_e <= lo_e);
    clip.lo    = lo_e[10:0];
    clip.hi    = last_e[10:0];
  end

endmodule

`default_nettype wire

// ----- rtl/tmpc_row_test.sv -----
`default_nettype none

// Tests one shape row against the pixel columns c0..c1.
module tmpc_row_test (
  input  wire logic [4:0] tile,
  input  wire logic [3:0] row,
  input  wire logic [3:0] c0,
  input  wire logic [3:0] c1,
  output logic            hit
);

  logic [15:0] mask;
  logic [15:0] bits;

  always_comb begin
    mask = (tmpc_pkg::ROW_FULL >> c0) & ~(tmpc_pkg::ROW_TAIL >> c1);
    bits = tmpc_pkg::SHAPE_ROM[tile][row];
    hit  = |(bits & mask);
  end

endmodule

`default_nettype wire

// ----- rtl/tmpc_checker.sv -----
`default_nettype none

`include "tile_map_pixel_collision_defines.svh"

// Port-level checks of the tile map collision block.
module tmpc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_hit
);

  // reset starts the clearing pass with no result pending
  `TMPC_ASSERT_RST(a_reset_busy, !rst_n, in_stall && !out_valid, "busy after reset expected")

  // no request is taken back to back
  `TMPC_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall, "request taken back to back")

  // a stalled result holds
  `TMPC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hit), "result lost")

endmodule

bind tile_map_pixel_collision tmpc_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_hit   (out_hit)
);

`default_nettype wire
